// ===== src/postfix_stack_evaluator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Postfix stack evaluator assertion macros
// Shared property forms for the checker, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_STACK_EVALUATOR_UNIT_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix stack evaluator package
// Token and error codes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int DATA_W = 32;
  localparam int FUNC_W = 3;
  localparam int ERR_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_PUSH = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_MUL  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DIV  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_POW  = 3'd5;

  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNDER = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVER  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_DIVZ  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RD_LEFT,
    ST_CAP_LEFT,
    ST_SETUP,
    ST_MUL_LOOP,
    ST_DIV_LOOP,
    ST_DIV_FIX,
    ST_WRITE,
    ST_FINISH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              load_token;
    logic              set_err;
    logic [ERR_W-1:0]  err_code;
    logic              push_tok;
    logic              rd_top;
    logic              rd_second;
    logic              cap_right;
    logic              cap_left_pop;
    logic              setup;
    logic              mul_step;
    logic              take_acc;
    logic              div_step;
    logic              div_fix;
    logic              push_res;
    logic              emit;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] tok_func;
    logic              tok_last;
    logic              depth_lt2;
    logic              depth_full;
    logic              right_zero;
    logic              right_neg;
    logic              expo_zero;
    logic              div_last;
    logic              out_free;
  } status_t;

endpackage

// ===== src/pse_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one read port, read data registered and held when not read.
// ----------------------------------------------------------------------------
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/pse_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix stack evaluator datapath
// Value stack, depth and error registers, shared multiplier and divider loop.
// ----------------------------------------------------------------------------
module pse_datapath #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pse_pkg::cmd_t                cmd,
  output pse_pkg::status_t             status,
  input  logic [pse_pkg::FUNC_W-1:0]   in_func,
  input  logic [pse_pkg::DATA_W-1:0]   in_value,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pse_pkg::DATA_W-1:0]   out_value,
  output logic [pse_pkg::ERR_W-1:0]    out_err
);

  import pse_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int CW = $clog2(DATA_W);

  logic [DW-1:0]     depth;
  logic [ERR_W-1:0]  lat_err;
  logic [FUNC_W-1:0] tok_func;
  logic [DATA_W-1:0] tok_value;
  logic              tok_last;
  logic [DATA_W-1:0] right;
  logic [DATA_W-1:0] left;
  logic [DATA_W-1:0] res;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] sq;
  logic [DATA_W-1:0] expo;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] divisor;
  logic              neg_q;
  logic [CW-1:0]     cnt;

  logic [DW-1:0]     depth_m1;
  logic [DW-1:0]     depth_m2;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   trial_diff;

  assign depth_m1  = depth - DW'(1);
  assign depth_m2  = depth - DW'(2);
  assign ram_we    = cmd.push_tok | cmd.push_res;
  assign ram_waddr = depth[AW-1:0];
  assign ram_wdata = cmd.push_tok ? tok_value : res;
  assign ram_re    = cmd.rd_top | cmd.rd_second;
  assign ram_raddr = cmd.rd_top ? depth_m1[AW-1:0] : depth_m2[AW-1:0];

  assign trial      = {rem, quo[DATA_W-1]};
  assign trial_diff = trial - {1'b0, divisor};

  pse_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    status.tok_func   = tok_func;
    status.tok_last   = tok_last;
    status.depth_lt2  = depth < DW'(2);
    status.depth_full = depth == DW'(STACK_DEPTH);
    status.right_zero = right == '0;
    status.right_neg  = right[DATA_W-1];
    status.expo_zero  = expo == '0;
    status.div_last   = cnt == '0;
    status.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      lat_err   <= ERR_NONE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.set_err && lat_err == ERR_NONE) begin
        lat_err <= cmd.err_code;
      end
      if (cmd.push_tok || cmd.push_res) begin
        depth <= depth + DW'(1);
      end else if (cmd.cap_left_pop) begin
        depth <= depth_m2;
      end
      if (cmd.emit) begin
        depth     <= '0;
        lat_err   <= ERR_NONE;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_token) begin
      tok_func  <= in_func;
      tok_value <= in_value;
      tok_last  <= in_last;
    end
    if (cmd.cap_right) begin
      right <= ram_rdata;
    end
    if (cmd.cap_left_pop) begin
      left <= ram_rdata;
    end
    if (cmd.emit) begin
      out_value <= (depth == '0) ? '0 : ram_rdata;
      out_err   <= lat_err;
    end
    if (cmd.setup) begin
      case (tok_func)
        FUNC_ADD: begin
          res <= left + right;
        end
        FUNC_SUB: begin
          res <= left - right;
        end
        FUNC_MUL: begin
          acc  <= left;
          sq   <= right;
          expo <= DATA_W'(1);
        end
        FUNC_POW: begin
          acc  <= DATA_W'(1);
          sq   <= left;
          expo <= right;
          if (left == DATA_W'(1)) begin
            res <= DATA_W'(1);
          end else if (left == '1) begin
            res <= right[0] ? '1 : DATA_W'(1);
          end else begin
            res <= '0;
          end
        end
        FUNC_DIV: begin
          res     <= '0;
          rem     <= '0;
          quo     <= left[DATA_W-1] ? -left : left;
          divisor <= right[DATA_W-1] ? -right : right;
          neg_q   <= left[DATA_W-1] ^ right[DATA_W-1];
          cnt     <= CW'(DATA_W - 1);
        end
        default: begin
          res <= '0;
        end
      endcase
    end
    if (cmd.mul_step) begin
      if (expo[0]) begin
        acc <= acc * sq;
      end
      sq   <= sq * sq;
      expo <= expo >> 1;
    end
    if (cmd.take_acc) begin
      res <= acc;
    end
    if (cmd.div_step) begin
      cnt <= cnt - CW'(1);
      if (!trial_diff[DATA_W]) begin
        rem <= trial_diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= trial[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
    if (cmd.div_fix) begin
      res <= neg_q ? -quo : quo;
    end
  end

endmodule

// ===== src/pse_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix stack evaluator controller
// Sequences one token at a time through stack reads, arithmetic and write-back.
// ----------------------------------------------------------------------------
module pse_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pse_pkg::status_t status,
  output pse_pkg::cmd_t    cmd
);

  import pse_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_token = 1'b1;
          state_next     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_next = ST_FINISH;
        if (status.tok_func == FUNC_PUSH) begin
          if (status.depth_full) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ERR_OVER;
          end else begin
            cmd.push_tok = 1'b1;
          end
        end else if (status.tok_func == FUNC_ADD || status.tok_func == FUNC_SUB ||
                     status.tok_func == FUNC_MUL || status.tok_func == FUNC_DIV ||
                     status.tok_func == FUNC_POW) begin
          if (status.depth_lt2) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ERR_UNDER;
          end else begin
            cmd.rd_top = 1'b1;
            state_next = ST_RD_LEFT;
          end
        end
      end
      ST_RD_LEFT: begin
        cmd.cap_right = 1'b1;
        cmd.rd_second = 1'b1;
        state_next    = ST_CAP_LEFT;
      end
      ST_CAP_LEFT: begin
        cmd.cap_left_pop = 1'b1;
        state_next       = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        case (status.tok_func)
          FUNC_MUL: begin
            state_next = ST_MUL_LOOP;
          end
          FUNC_POW: begin
            state_next = status.right_neg ? ST_WRITE : ST_MUL_LOOP;
          end
          FUNC_DIV: begin
            if (status.right_zero) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ERR_DIVZ;
              state_next   = ST_WRITE;
            end else begin
              state_next = ST_DIV_LOOP;
            end
          end
          default: begin
            state_next = ST_WRITE;
          end
        endcase
      end
      ST_MUL_LOOP: begin
        if (status.expo_zero) begin
          cmd.take_acc = 1'b1;
          state_next   = ST_WRITE;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      ST_DIV_LOOP: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_DIV_FIX;
        end
      end
      ST_DIV_FIX: begin
        cmd.div_fix = 1'b1;
        state_next  = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.push_res = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.tok_last) begin
          cmd.rd_top = 1'b1;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/postfix_stack_evaluator_unit.sv =====
// Tokens are taken one at a time: a push, an unused kind or a stack error passes dispatch
// and finish; an operator also reads both operands, sets up and writes back its result,
// with a square-and-multiply loop for multiply and power and a bit-per-cycle divider loop
// for divide (skipped by divide by zero and a negative-exponent power). A last token adds
// a top-of-stack read; the result is then held in an output register until taken.
// Synchronous reset empties the stack and clears the latched error and the output valid.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix stack evaluator
// Evaluates integer postfix expressions on a value stack, one token per transaction.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_unit #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [pse_pkg::DATA_W-1:0]  s_tdata,   // [31:0] operand_value
  input  logic [pse_pkg::FUNC_W-1:0]  s_tuser,   // [2:0] func
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [pse_pkg::DATA_W-1:0]  m_tdata,   // [31:0] result_value
  output logic [pse_pkg::ERR_W-1:0]   m_tuser    // [1:0] error_status
);

  import pse_pkg::*;

  cmd_t    cmd;
  status_t status;

  pse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pse_datapath #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_func   (s_tuser),
    .in_value  (s_tdata),
    .in_last   (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (m_tdata),
    .out_err   (m_tuser)
  );

endmodule

// ===== src/pse_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix stack evaluator checker
// Port-level properties of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "postfix_stack_evaluator_unit_defines.svh"

module pse_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [pse_pkg::DATA_W-1:0]  s_tdata,
  input logic [pse_pkg::FUNC_W-1:0]  s_tuser,
  input logic                        s_tlast,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [pse_pkg::DATA_W-1:0]  m_tdata,
  input logic [pse_pkg::ERR_W-1:0]   m_tuser
);

  `PSE_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  `PSE_ASSERT_NXT(a_one_token, s_tvalid && s_tready,
    !s_tready, "second token accepted while one is in work")

  `PSE_ASSERT_NXT(a_no_spurious, s_tvalid && s_tready && !s_tlast && !m_tvalid,
    !m_tvalid, "result raised by a token that is not last")

  `PSE_ASSERT_IMP(a_known_inputs_ready, s_tready && s_tvalid,
    !$isunknown(s_tuser) && !$isunknown(s_tlast), "token kind or last flag unknown")

endmodule

bind postfix_stack_evaluator_unit pse_checker u_pse_checker (.*);

// ===== verif/pse_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix evaluator result checker
// Tracks the value stack and latched error on every accepted token, queues the
// result that each last token should return, and compares returned results.
// ----------------------------------------------------------------------------
module pse_result_checker #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [pse_pkg::DATA_W-1:0]  s_tdata,
  input  logic [pse_pkg::FUNC_W-1:0]  s_tuser,
  input  logic                        s_tlast,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [pse_pkg::DATA_W-1:0]  m_tdata,
  input  logic [pse_pkg::ERR_W-1:0]   m_tuser,
  output int                          mismatches,
  output int                          pending
);
  import pse_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [ERR_W-1:0]  status;
  } eval_result_t;

  eval_result_t      expected_results[$];
  logic [DATA_W-1:0] value_stack [STACK_DEPTH];
  int                depth = 0;
  logic [ERR_W-1:0]  first_err = ERR_NONE;
  int                fail_total = 0;

  function automatic void latch_error(logic [ERR_W-1:0] code);
    if (first_err == ERR_NONE) first_err = code;
  endfunction

  function automatic void push_operand(logic [DATA_W-1:0] v);
    if (depth >= STACK_DEPTH) begin
      latch_error(ERR_OVER);
    end else begin
      value_stack[depth] = v;
      depth++;
    end
  endfunction

  function automatic logic [DATA_W-1:0] raise_power(logic [DATA_W-1:0] base,
                                                    logic [DATA_W-1:0] expo);
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] sq;
    acc = 1;
    sq = base;
    if (expo[DATA_W-1]) begin
      if (base == 1) return 1;
      if (base == '1) return expo[0] ? '1 : 1;
      return '0;
    end
    while (expo != 0) begin
      if (expo[0]) acc = acc * sq;
      sq = sq * sq;
      expo = expo >> 1;
    end
    return acc;
  endfunction

  function automatic logic [DATA_W-1:0] quotient(logic [DATA_W-1:0] num,
                                                 logic [DATA_W-1:0] den);
    longint n;
    longint d;
    longint q;
    n = longint'($signed(num));
    d = longint'($signed(den));
    q = n / d;
    return q[DATA_W-1:0];
  endfunction

  function automatic void apply_token(logic [FUNC_W-1:0] func, logic [DATA_W-1:0] v,
                                      logic last);
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] res;
    eval_result_t      r;
    if (func == FUNC_PUSH) begin
      push_operand(v);
    end else if (func <= FUNC_POW) begin
      if (depth < 2) begin
        latch_error(ERR_UNDER);
      end else begin
        rhs = value_stack[depth-1];
        lhs = value_stack[depth-2];
        depth -= 2;
        case (func)
          FUNC_ADD: res = lhs + rhs;
          FUNC_SUB: res = lhs - rhs;
          FUNC_MUL: res = lhs * rhs;
          FUNC_DIV: begin
            if (rhs == 0) begin
              latch_error(ERR_DIVZ);
              res = '0;
            end else begin
              res = quotient(lhs, rhs);
            end
          end
          default: res = raise_power(lhs, rhs);
        endcase
        push_operand(res);
      end
    end
    if (last) begin
      r.value = (depth > 0) ? value_stack[depth-1] : '0;
      r.status = first_err;
      expected_results.push_back(r);
      depth = 0;
      first_err = ERR_NONE;
    end
  endfunction

  always @(posedge clk) begin : monitor
    eval_result_t want;
    if (rst) begin
      depth = 0;
      first_err = ERR_NONE;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          if (fail_total < 50) $error("Result transaction with nothing expected: %0d / %0d",
                                      $signed(m_tdata), m_tuser);
          fail_total++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata !== want.value) begin
            if (fail_total < 50) $error("result_value: expected %0d, got %0d",
                                        $signed(want.value), $signed(m_tdata));
            fail_total++;
          end
          if (m_tuser !== want.status) begin
            if (fail_total < 50) $error("error_status: expected %0d, got %0d",
                                        want.status, m_tuser);
            fail_total++;
          end
        end
      end
      if (s_tvalid && s_tready) apply_token(s_tuser, s_tdata, s_tlast);
    end
    pending <= expected_results.size();
    mismatches <= fail_total;
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix stack evaluator testbench
// Feeds directed corner expressions, then random well-formed and broken token
// streams with random gaps on both sides, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
  import pse_pkg::*;

  localparam int STACK_DEPTH   = 32;
  localparam int TOKEN_COUNT   = 1700;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 64;

  localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd7;
  localparam logic [DATA_W-1:0] INT_MIN      = 32'h8000_0000;
  localparam logic [DATA_W-1:0] INT_MAX      = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MINUS_ONE    = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] MINUS_THREE  = 32'hFFFF_FFFD;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic [FUNC_W-1:0] s_tuser = FUNC_PUSH;
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic [ERR_W-1:0]  m_tuser;

  int fail_count;
  int pending_results;
  int tokens_sent = 0;
  int idle_cycles = 0;
  bit src_gaps = 1'b1;
  bit sink_gaps = 1'b1;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  postfix_stack_evaluator_unit #(.STACK_DEPTH(STACK_DEPTH)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  pse_result_checker #(.STACK_DEPTH(STACK_DEPTH)) chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .mismatches(fail_count), .pending(pending_results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_gap(bit enabled);
    int roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 90);
  endfunction

  function automatic logic [DATA_W-1:0] rand_operand();
    int roll;
    roll = $urandom_range(0, 11);
    case (roll)
      0: return INT_MIN;
      1: return INT_MAX;
      2: return MINUS_ONE;
      3: return '0;
      4: return 1;
      5, 6, 7, 8: return $urandom_range(0, 16) - 8;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] rand_operator();
    return FUNC_W'($urandom_range(FUNC_ADD, FUNC_POW));
  endfunction

  // The sink process: random stalls, plus one long hold-off on request.
  initial begin : sink
    int stall;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        m_tready <= 1'b1;
      end else begin
        stall = pick_gap(sink_gaps);
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_token(input logic [FUNC_W-1:0] func, input logic [DATA_W-1:0] v,
                            input logic last);
    int gap;
    gap = pick_gap(src_gaps);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= (func == FUNC_PUSH) ? v : $urandom();
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tokens_sent++;
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic send_expression(input int operands);
    int depth;
    int pushed;
    depth = 0;
    pushed = 0;
    while (pushed < operands || depth > 1) begin
      if (pushed < operands && (depth < 2 || $urandom_range(0, 2) != 0)) begin
        send_token(FUNC_PUSH, rand_operand(), (pushed + 1 == operands) && (depth == 0));
        pushed++;
        depth++;
      end else begin
        send_token(rand_operator(), '0, (pushed == operands) && (depth == 2));
        depth--;
      end
    end
  endtask

  task automatic send_deep_expression();
    int pushes;
    int ops;
    pushes = $urandom_range(STACK_DEPTH - 3, STACK_DEPTH + 3);
    ops = $urandom_range(0, 3);
    for (int i = 0; i < pushes; i++)
      send_token(FUNC_PUSH, rand_operand(), (ops == 0) && (i == pushes - 1));
    for (int i = 0; i < ops; i++)
      send_token(rand_operator(), '0, i == ops - 1);
  endtask

  task automatic send_noise(input int count);
    int roll;
    logic [FUNC_W-1:0] func;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 9);
      if (roll < 4) func = FUNC_PUSH;
      else if (roll < 9) func = rand_operator();
      else func = $urandom_range(0, 1) ? FUNC_SPARE_B : FUNC_SPARE_A;
      send_token(func, rand_operand(), (i == count - 1) || ($urandom_range(0, 5) == 0));
    end
  endtask

  initial begin : stimulus
    int kind;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_token(FUNC_ADD, '0, 1'b1);
    send_token(FUNC_PUSH, INT_MAX, 1'b0);
    send_token(FUNC_PUSH, 1, 1'b0);
    send_token(FUNC_ADD, '0, 1'b1);
    send_token(FUNC_PUSH, INT_MIN, 1'b0);
    send_token(FUNC_PUSH, MINUS_ONE, 1'b0);
    send_token(FUNC_DIV, '0, 1'b1);
    send_token(FUNC_PUSH, 7, 1'b0);
    send_token(FUNC_PUSH, 0, 1'b0);
    send_token(FUNC_DIV, '0, 1'b0);
    send_token(FUNC_SUB, '0, 1'b1);
    send_token(FUNC_PUSH, 0, 1'b0);
    send_token(FUNC_PUSH, 0, 1'b0);
    send_token(FUNC_POW, '0, 1'b1);
    send_token(FUNC_PUSH, MINUS_ONE, 1'b0);
    send_token(FUNC_PUSH, MINUS_THREE, 1'b0);
    send_token(FUNC_POW, '0, 1'b1);
    send_token(FUNC_PUSH, 2, 1'b0);
    send_token(FUNC_PUSH, MINUS_ONE, 1'b0);
    send_token(FUNC_POW, '0, 1'b1);
    send_token(FUNC_PUSH, 1, 1'b0);
    send_token(FUNC_PUSH, INT_MIN, 1'b0);
    send_token(FUNC_POW, '0, 1'b1);
    send_token(FUNC_PUSH, 9, 1'b0);
    send_token(FUNC_SPARE_A, '0, 1'b0);
    send_token(FUNC_SPARE_B, '0, 1'b1);
    send_token(FUNC_SPARE_A, '0, 1'b1);
    wait_results_drained();

    while (tokens_sent < TOKEN_COUNT) begin
      if ($urandom_range(0, 15) == 0) begin
        src_gaps = 1'($urandom_range(0, 1));
        sink_gaps = 1'($urandom_range(0, 1));
      end
      if (!hold_done && tokens_sent > TOKEN_COUNT / 3) begin
        hold_req = 1'b1;
        repeat (6) send_expression(2);
        hold_done = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 75) send_expression($urandom_range(1, 6));
      else if (kind < 80) send_expression($urandom_range(7, 20));
      else if (kind < 84) send_deep_expression();
      else send_noise($urandom_range(1, 8));
      if ($urandom_range(0, 19) == 0) wait_results_drained();
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
